>>> hw/rtl/tac_pkg.sv
package tac_pkg;

    // Command codes carried in the tuser bit of the input.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_INDEX = 1'b1;

    // Cull reason codes.
    localparam logic [1:0] REASON_KEPT    = 2'd0;
    localparam logic [1:0] REASON_FRUSTUM = 2'd1;
    localparam logic [1:0] REASON_BACK    = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_SCALE_X  = 3'd0;
    localparam logic [2:0] REG_SCALE_Y  = 3'd1;
    localparam logic [2:0] REG_OFFSET_X = 3'd2;
    localparam logic [2:0] REG_OFFSET_Y = 3'd3;
    localparam logic [2:0] REG_BF_EN    = 3'd4;
    localparam logic [2:0] REG_FRONT_CW = 3'd5;

    localparam int ONE_Q16 = 65536;

    // Viewport and winding settings.
    typedef struct packed {
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic               bf_en;
        logic               front_cw;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       div_start;
        logic [1:0] div_sel;
        logic       map_x;
        logic       map_y;
        logic       write_vtx;
        logic       rd_vtx;
        logic [1:0] rd_sel;
        logic       cross_step;
        logic [1:0] cross_sel;
        logic       clear_sum;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
    } t_sts;

endpackage

>>> hw/rtl/tac_div.sv
// Iterative signed divider: (num * 2^16) / den, truncated toward zero,
// one quotient bit a cycle over a 48-bit dividend.
module tac_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic signed [48:0] o_quot
);
    logic [47:0] r_dvd;
    logic [31:0] r_den;
    logic [32:0] r_rem;
    logic [47:0] r_quo;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_neg;
    logic        r_done;
    logic [32:0] n_trial;
    logic [32:0] n_shift;

    assign n_shift = {r_rem[31:0], r_dvd[47]};
    assign n_trial = n_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd48;
                r_rem  <= '0;
                r_quo  <= '0;
                r_dvd  <= {(i_num[31] ? 32'(-i_num) : 32'(i_num)), 16'd0};
                r_den  <= i_den[31] ? 32'(-i_den) : 32'(i_den);
                r_neg  <= i_num[31] ^ i_den[31];
            end else if (r_busy) begin
                r_dvd <= {r_dvd[46:0], 1'b0};
                if (!n_trial[32]) begin
                    r_rem <= n_trial;
                    r_quo <= {r_quo[46:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_quo <= {r_quo[46:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
endmodule

>>> hw/rtl/tac_datapath.sv
// Datapath: divider, viewport map, vertex memories, cross-product sum.
module tac_datapath #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tac_pkg::t_cfg       i_cfg,
    input  tac_pkg::t_cmd       i_cmd,
    output tac_pkg::t_sts       o_sts,
    input  logic [9:0]          i_index,
    input  logic signed [31:0]  i_clip_x,
    input  logic signed [31:0]  i_clip_y,
    input  logic signed [31:0]  i_clip_z,
    input  logic signed [31:0]  i_clip_w,
    input  logic [9:0]          i_idx_a,
    input  logic [9:0]          i_idx_b,
    input  logic [9:0]          i_idx_c,
    output logic                o_all_inside,
    output logic signed [65:0]  o_sum
);
    import tac_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    logic               div_done;
    logic signed [48:0] quot;
    logic signed [31:0] div_num;

    // Vertex stores.
    logic               mem_in [MAX_VERTICES];
    logic signed [31:0] mem_x  [MAX_VERTICES];
    logic signed [31:0] mem_y  [MAX_VERTICES];

    logic signed [31:0] r_nx, r_ny;
    logic               r_ins;
    logic [1:0]         r_dsel;
    logic signed [31:0] r_sx;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_vx [3];
    logic signed [31:0] r_vy [3];
    logic               r_vin [3];
    logic signed [65:0] r_sum;
    logic signed [63:0] r_p1, r_p2;
    logic               r_cross_ph;
    logic               r_map_ph;

    logic signed [31:0] sat_q;
    logic               q_in;
    logic signed [47:0] fl;
    logic signed [48:0] mapped;
    logic signed [31:0] mapped_sat;
    logic [9:0]         rd_idx;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic signed [31:0] xa, ya, xb, yb;
    logic signed [64:0] diff;
    logic signed [64:0] term;
    logic               vtx_ok;

    always_comb begin
        case (i_cmd.div_sel)
            2'd0:    div_num = i_clip_x;
            2'd1:    div_num = i_clip_y;
            default: div_num = i_clip_z;
        endcase
    end

    tac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (i_clip_w),
        .o_done  (div_done),
        .o_quot  (quot)
    );
    assign o_sts.div_done = div_done;

    // Saturated quotient and range check; zero w gives zero and outside.
    always_comb begin
        if (i_clip_w == 32'sd0) sat_q = '0;
        else if (quot > 49'sh7FFFFFFF) sat_q = 32'h7FFFFFFF;
        else if (quot < -49'sh80000000) sat_q = 32'h80000000;
        else sat_q = quot[31:0];
        q_in = (i_clip_w != 32'sd0) && (quot >= -49'sd65536) && (quot <= 49'sd65536);
    end

    // Viewport map: floor shift of the product, add offset, saturate.
    assign fl     = 48'(r_prod >>> 16);
    assign mapped = 49'(fl) + 49'(r_map_ph ? i_cfg.offset_y : i_cfg.offset_x);
    always_comb begin
        if (mapped > 49'sh7FFFFFFF) mapped_sat = 32'h7FFFFFFF;
        else if (mapped < -49'sh80000000) mapped_sat = 32'h80000000;
        else mapped_sat = mapped[31:0];
    end

    assign wr_addr = AW'(i_index);

    always_comb begin
        case (i_cmd.rd_sel)
            2'd0:    rd_idx = i_idx_a;
            2'd1:    rd_idx = i_idx_b;
            default: rd_idx = i_idx_c;
        endcase
    end
    assign rd_addr = AW'(rd_idx);
    assign vtx_ok  = 32'(rd_idx) < MAX_VERTICES;

    // Cross-product operands for the selected edge.
    always_comb begin
        case (i_cmd.cross_sel)
            2'd0: begin
                xa = r_vx[0]; ya = r_vy[0]; xb = r_vx[1]; yb = r_vy[1];
            end
            2'd1: begin
                xa = r_vx[1]; ya = r_vy[1]; xb = r_vx[2]; yb = r_vy[2];
            end
            default: begin
                xa = r_vx[2]; ya = r_vy[2]; xb = r_vx[0]; yb = r_vy[0];
            end
        endcase
    end

    // Truncate toward zero after the 2^-32 scale.
    assign diff = 65'(r_p1) - 65'(r_p2);
    assign term = (diff < 0 && diff[31:0] != 32'd0) ? (diff >>> 32) + 65'sd1 : diff >>> 32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cross_ph <= 1'b0;
            r_map_ph   <= 1'b0;
            r_ins      <= 1'b0;
            r_dsel     <= '0;
            r_sum      <= '0;
        end else begin
            // Remember which coordinate the running division belongs to.
            if (i_cmd.div_start) r_dsel <= i_cmd.div_sel;
            if (div_done) begin
                case (r_dsel)
                    2'd0: begin r_nx <= sat_q; r_ins <= q_in; end
                    2'd1: begin r_ny <= sat_q; r_ins <= r_ins & q_in; end
                    default: r_ins <= r_ins & q_in;
                endcase
            end
            // Map x, then y; each product is registered before the add.
            if (i_cmd.map_x) begin
                r_prod   <= 64'(r_nx) * 64'(i_cfg.scale_x);
                r_map_ph <= 1'b0;
            end else if (i_cmd.map_y) begin
                r_sx     <= mapped_sat;
                r_prod   <= 64'(r_ny) * 64'(i_cfg.scale_y);
                r_map_ph <= 1'b1;
            end
            if (i_cmd.write_vtx && 32'(i_index) < MAX_VERTICES) begin
                mem_in[wr_addr] <= r_ins;
                mem_x[wr_addr]  <= r_sx;
                mem_y[wr_addr]  <= mapped_sat;
            end
            if (i_cmd.rd_vtx) begin
                r_vx[i_cmd.rd_sel]  <= mem_x[rd_addr];
                r_vy[i_cmd.rd_sel]  <= mem_y[rd_addr];
                r_vin[i_cmd.rd_sel] <= vtx_ok & mem_in[rd_addr];
            end
            if (i_cmd.clear_sum) begin
                r_sum      <= '0;
                r_cross_ph <= 1'b0;
            end else if (i_cmd.cross_step) begin
                // Phase 0 forms the products, phase 1 accumulates.
                if (!r_cross_ph) begin
                    r_p1 <= 64'(xa) * 64'(yb);
                    r_p2 <= 64'(xb) * 64'(ya);
                end else begin
                    r_sum <= r_sum + 66'(term);
                end
                r_cross_ph <= ~r_cross_ph;
            end
        end
    end

    assign o_all_inside = r_vin[0] & r_vin[1] & r_vin[2];
    assign o_sum        = r_sum;
endmodule

>>> hw/rtl/tac_ctrl.sv
// Controller: sequences loads and triangle evaluation.
module tac_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_command,
    input  logic [9:0]          i_index,
    output tac_pkg::t_cmd       o_cmd,
    input  tac_pkg::t_sts       i_sts,
    input  tac_pkg::t_cfg       i_cfg,
    input  logic                i_all_inside,
    input  logic signed [65:0]  i_sum,
    output logic [9:0]          o_idx_a,
    output logic [9:0]          o_idx_b,
    output logic [9:0]          o_idx_c,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_reason
);
    import tac_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_MAPX, S_MAPY, S_WRITE,
        S_READ, S_RWAIT, S_CROSS, S_DECIDE
    } t_state;

    t_state     r_state;
    logic [1:0] r_cnt;
    logic [1:0] r_step;
    logic [1:0] r_asm;
    logic [9:0] r_a, r_b, r_c;
    logic       r_ovalid;
    logic [1:0] r_reason;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE) && !r_ovalid;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd            = '0;
        o_cmd.div_sel    = r_cnt;
        o_cmd.rd_sel     = r_cnt;
        o_cmd.cross_sel  = r_cnt;
        o_cmd.div_start  = accept && (i_command == CMD_LOAD);
        o_cmd.map_x      = (r_state == S_MAPX);
        o_cmd.map_y      = (r_state == S_MAPY);
        o_cmd.write_vtx  = (r_state == S_WRITE);
        o_cmd.rd_vtx     = (r_state == S_READ);
        o_cmd.cross_step = (r_state == S_CROSS);
        o_cmd.clear_sum  = (r_state == S_RWAIT);
        if (r_state == S_DIV && i_sts.div_done && r_cnt != 2'd2) begin
            o_cmd.div_start = 1'b1;
            o_cmd.div_sel   = r_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_step   <= '0;
            r_asm    <= '0;
            r_a      <= '0;
            r_b      <= '0;
            r_c      <= '0;
            r_ovalid <= 1'b0;
            r_reason <= REASON_KEPT;
        end else begin
            if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (accept) begin
                        if (i_command == CMD_LOAD) begin
                            r_state <= S_DIV;
                        end else if (r_asm == 2'd0) begin
                            r_a <= i_index; r_asm <= 2'd1;
                        end else if (r_asm == 2'd1) begin
                            r_b <= i_index; r_asm <= 2'd2;
                        end else begin
                            r_c <= i_index; r_asm <= 2'd0;
                            r_state <= S_READ;
                        end
                    end
                end
                S_DIV: if (i_sts.div_done) begin
                    if (r_cnt == 2'd2) begin
                        r_state <= S_MAPX;
                        r_cnt   <= '0;
                    end else r_cnt <= r_cnt + 2'd1;
                end
                S_MAPX:  r_state <= S_MAPY;
                S_MAPY:  r_state <= S_WRITE;
                S_WRITE: r_state <= S_IDLE;
                S_READ: begin
                    if (r_cnt == 2'd2) begin
                        r_state <= S_RWAIT;
                        r_cnt   <= '0;
                    end else r_cnt <= r_cnt + 2'd1;
                end
                S_RWAIT: begin
                    r_state <= S_CROSS;
                    r_step  <= '0;
                end
                S_CROSS: begin
                    // Per edge: a multiply step, then an accumulate step.
                    if (r_step[0]) begin
                        r_step <= '0;
                        if (r_cnt == 2'd2) r_state <= S_DECIDE;
                        else r_cnt <= r_cnt + 2'd1;
                    end else begin
                        r_step <= r_step + 2'd1;
                    end
                end
                S_DECIDE: begin
                    if (!i_all_inside) r_reason <= REASON_FRUSTUM;
                    else if (i_cfg.bf_en &&
                             ((i_sum > 0 && i_cfg.front_cw) ||
                              (i_sum < 0 && !i_cfg.front_cw)))
                        r_reason <= REASON_BACK;
                    else r_reason <= REASON_KEPT;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_idx_a     = r_a;
    assign o_idx_b     = r_b;
    assign o_idx_c     = r_c;
    assign o_out_valid = r_ovalid;
    assign o_reason    = r_reason;

    // A pending result stays offered until it is taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_out_ready) |=> r_ovalid)
        else $error("result dropped while stalled");
    // No input is taken outside the idle state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (r_state == S_IDLE))
        else $error("input taken while busy");
    // A triangle closes only from the third index.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && $past(r_state) == S_DECIDE) |-> (r_asm == 2'd0))
        else $error("assembly count out of step");
endmodule

>>> hw/rtl/triangle_assembly_and_cull.sv
// Channel | Direction | Contents
// s_axis  | in        | tuser: command; tdata: vertex_index, clip_x, clip_y, clip_z, clip_w
// m_axis  | out       | tdata: keep, cull_reason, first/second/third_index
// apb     | in/out    | six registers at byte addresses 0,4,..,20
//
// A vertex load holds the input while three divisions by w
// run one after another on one shared divider, then the x and y viewport
// multiplies and a store write. Index items before the third of a triangle
// are taken in the idle state; the third offers its result after reading
// its vertices from memory, forming the cross products of its edges and deciding.
// Reset is synchronous and active low; vertex memories are not cleared.
// A stalled result holds the block before its next input is taken.
module triangle_assembly_and_cull #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[0]
    input  logic         s_axis_tuser,
    // vertex_index[9:0], clip_x[41:10], clip_y[73:42], clip_z[105:74],
    // clip_w[137:106], zero fill to 144 bits
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // keep[0], cull_reason[2:1], first_index[12:3], second_index[22:13],
    // third_index[32:23], zero fill to 40 bits
    output logic [39:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import tac_pkg::*;

    t_cfg               r_cfg;
    t_cmd               cmd;
    t_sts               sts;
    logic [9:0]         idx_a, idx_b, idx_c;
    logic               all_inside;
    logic signed [65:0] sum;
    logic [1:0]         reason;
    logic [2:0]         reg_sel;
    logic [137:0]       r_load;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:2];

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                REG_SCALE_X:  r_cfg.scale_x  <= pwdata;
                REG_SCALE_Y:  r_cfg.scale_y  <= pwdata;
                REG_OFFSET_X: r_cfg.offset_x <= pwdata;
                REG_OFFSET_Y: r_cfg.offset_y <= pwdata;
                REG_BF_EN:    r_cfg.bf_en    <= pwdata[0];
                REG_FRONT_CW: r_cfg.front_cw <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (reg_sel)
            REG_SCALE_X:  prdata = r_cfg.scale_x;
            REG_SCALE_Y:  prdata = r_cfg.scale_y;
            REG_OFFSET_X: prdata = r_cfg.offset_x;
            REG_OFFSET_Y: prdata = r_cfg.offset_y;
            REG_BF_EN:    prdata = {31'd0, r_cfg.bf_en};
            REG_FRONT_CW: prdata = {31'd0, r_cfg.front_cw};
            default:      prdata = '0;
        endcase
    end

    tac_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_command    (s_axis_tuser),
        .i_index      (s_axis_tdata[9:0]),
        .o_cmd        (cmd),
        .i_sts        (sts),
        .i_cfg        (r_cfg),
        .i_all_inside (all_inside),
        .i_sum        (sum),
        .o_idx_a      (idx_a),
        .o_idx_b      (idx_b),
        .o_idx_c      (idx_c),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_reason     (reason)
    );

    // Load fields stay on the bus only at acceptance; hold them for the load.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) r_load <= s_axis_tdata[137:0];
    end

    tac_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_index      (r_load[9:0]),
        .i_clip_x     (cmd.div_start && s_axis_tready ? s_axis_tdata[41:10] : r_load[41:10]),
        .i_clip_y     (r_load[73:42]),
        .i_clip_z     (r_load[105:74]),
        .i_clip_w     (cmd.div_start && s_axis_tready ? s_axis_tdata[137:106]
                                                      : r_load[137:106]),
        .i_idx_a      (idx_a),
        .i_idx_b      (idx_b),
        .i_idx_c      (idx_c),
        .o_all_inside (all_inside),
        .o_sum        (sum)
    );

    assign m_axis_tdata = {7'd0, idx_c, idx_b, idx_a, reason, (reason == REASON_KEPT)};
endmodule

>>> verif/tb.sv
module tb;
    import tac_pkg::*;

    // Input item and triangle result as the block sees them.
    typedef struct {
        logic        cmd;
        logic [9:0]  idx;
        logic signed [31:0] cx, cy, cz, cw;
    } t_item;

    typedef struct {
        logic       keep;
        logic [1:0] reason;
        logic [9:0] ia, ib, ic;
    } t_tri;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic         s_axis_tuser;
    logic [143:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [39:0]  m_axis_tdata;
    logic         psel, penable, pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    triangle_assembly_and_cull u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow of the block: viewport settings, vertex stores, assembly state.
    logic signed [31:0] vp_scale_x, vp_scale_y, vp_off_x, vp_off_y;
    logic               bf_en, front_cw;
    logic               vtx_inside [1024];
    logic signed [31:0] vtx_sx [1024];
    logic signed [31:0] vtx_sy [1024];
    bit                 vtx_loaded [1024];
    int                 asm_count = 0;
    logic [9:0]         hold_a = '0;
    logic [9:0]         hold_b = '0;

    t_item pending_items[$];
    t_tri  expected_tris[$];

    int  send_idle_pct, recv_idle_pct;
    bit  recv_hold;
    int  hold_cycles;
    int  mismatches, results_seen, cycle_count;
    int  kept_seen, frustum_seen, back_seen;

    // Clock: period 8.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic logic signed [63:0] sat32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [63:0] persp_divide(logic signed [31:0] c,
                                                       logic signed [31:0] w);
        logic signed [63:0] num, den;
        if (w == 0) return 0;
        num = 64'(c) * 65536;
        den = 64'(w);
        return num / den;
    endfunction

    function automatic logic signed [31:0] viewport_map(logic signed [63:0] ndc,
                                                        logic signed [31:0] scale,
                                                        logic signed [31:0] offset);
        logic signed [127:0] p;
        p = 128'(sat32(ndc)) * 128'(scale);
        p = p >>> 16;
        return 32'(sat32(64'(p) + 64'(offset)));
    endfunction

    // Truncated-toward-zero value of the cross product scaled by 2^-32.
    function automatic logic signed [63:0] cross_trunc(logic signed [31:0] x1,
                                                       logic signed [31:0] y1,
                                                       logic signed [31:0] x2,
                                                       logic signed [31:0] y2);
        logic signed [127:0] d;
        logic signed [127:0] q;
        d = 128'(x1) * 128'(y2) - 128'(x2) * 128'(y1);
        q = (d < 0) ? -((-d) >>> 32) : (d >>> 32);
        return 64'(q);
    endfunction

    function automatic void predict_item(t_item it);
        logic signed [63:0] nx, ny, nz, area;
        logic               ins;
        t_tri               exp_tri;
        if (it.cmd == CMD_LOAD) begin
            nx = persp_divide(it.cx, it.cw);
            ny = persp_divide(it.cy, it.cw);
            nz = persp_divide(it.cz, it.cw);
            ins = (it.cw != 0) && nx >= -ONE_Q16 && nx <= ONE_Q16 &&
                  ny >= -ONE_Q16 && ny <= ONE_Q16 && nz >= -ONE_Q16 && nz <= ONE_Q16;
            vtx_inside[it.idx] = ins;
            vtx_sx[it.idx] = viewport_map(nx, vp_scale_x, vp_off_x);
            vtx_sy[it.idx] = viewport_map(ny, vp_scale_y, vp_off_y);
            vtx_loaded[it.idx] = 1'b1;
            return;
        end
        if (asm_count == 0) begin
            hold_a = it.idx;
            asm_count = 1;
            return;
        end
        if (asm_count == 1) begin
            hold_b = it.idx;
            asm_count = 2;
            return;
        end
        asm_count = 0;
        exp_tri.ia = hold_a;
        exp_tri.ib = hold_b;
        exp_tri.ic = it.idx;
        exp_tri.reason = REASON_KEPT;
        if (!vtx_inside[exp_tri.ia] || !vtx_inside[exp_tri.ib] ||
            !vtx_inside[exp_tri.ic]) begin
            exp_tri.reason = REASON_FRUSTUM;
        end else if (bf_en) begin
            area = cross_trunc(vtx_sx[exp_tri.ia], vtx_sy[exp_tri.ia],
                               vtx_sx[exp_tri.ib], vtx_sy[exp_tri.ib])
                 + cross_trunc(vtx_sx[exp_tri.ib], vtx_sy[exp_tri.ib],
                               vtx_sx[exp_tri.ic], vtx_sy[exp_tri.ic])
                 + cross_trunc(vtx_sx[exp_tri.ic], vtx_sy[exp_tri.ic],
                               vtx_sx[exp_tri.ia], vtx_sy[exp_tri.ia]);
            if ((area > 0 && front_cw) || (area < 0 && !front_cw))
                exp_tri.reason = REASON_BACK;
        end
        exp_tri.keep = (exp_tri.reason == REASON_KEPT);
        expected_tris.insert(expected_tris.size(), exp_tri);
    endfunction

    // Stimulus builders. Index items are only given for slots already loaded.
    function automatic void add_load(logic [9:0] idx, logic signed [31:0] x,
                                     logic signed [31:0] y, logic signed [31:0] z,
                                     logic signed [31:0] w);
        t_item it;
        it.cmd = CMD_LOAD;
        it.idx = idx;
        it.cx = x; it.cy = y; it.cz = z; it.cw = w;
        pending_items.insert(pending_items.size(), it);
        vtx_loaded[idx] = 1'b1;
    endfunction

    function automatic void add_index(logic [9:0] idx);
        t_item it;
        it.cmd = CMD_INDEX;
        it.idx = idx;
        it.cx = $urandom; it.cy = $urandom; it.cz = $urandom; it.cw = $urandom;
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic logic signed [31:0] rand_coord(logic signed [31:0] w);
        logic signed [31:0] aw;
        aw = (w < 0) ? -w : w;
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return aw;
            2: return -aw;
            3: return aw + 1;
            default: return $signed($urandom_range(0, 2 * (aw & 32'h00ff_ffff))) -
                            (aw & 32'h00ff_ffff);
        endcase
    endfunction

    function automatic logic [9:0] rand_slot();
        case ($urandom_range(0, 5))
            0: return 10'd0;
            1: return 10'd1023;
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    function automatic void add_random_load(logic [9:0] idx);
        logic signed [31:0] w;
        case ($urandom_range(0, 9))
            0: w = 0;
            1: w = $urandom;
            2: w = -$signed($urandom_range(1, 32'h0040_0000));
            default: w = $urandom_range(1, 32'h0040_0000);
        endcase
        add_load(idx, rand_coord(w), rand_coord(w), rand_coord(w), w);
    endfunction

    function automatic logic [9:0] loaded_slot();
        logic [9:0] s;
        do s = rand_slot(); while (!vtx_loaded[s]);
        return s;
    endfunction

    // Random phase: mostly load-three-then-draw sequences, some reuse of old slots.
    function automatic void add_random_phase(int n);
        logic [9:0] s0, s1, s2;
        int         start;
        start = pending_items.size();
        while (pending_items.size() - start < n) begin
            s0 = rand_slot(); s1 = rand_slot(); s2 = rand_slot();
            if ($urandom_range(0, 3) != 0) begin
                add_random_load(s0);
                add_random_load(s1);
                add_random_load(s2);
            end else begin
                s0 = loaded_slot(); s1 = loaded_slot(); s2 = loaded_slot();
            end
            add_index(s0);
            if ($urandom_range(0, 9) == 0) add_random_load(rand_slot());
            add_index(s1);
            add_index(s2);
        end
    endfunction

    // Register write over the configuration port, also updating the shadow.
    task automatic write_reg(logic [2:0] reg_idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (reg_idx)
            REG_SCALE_X:  vp_scale_x = value;
            REG_SCALE_Y:  vp_scale_y = value;
            REG_OFFSET_X: vp_off_x = value;
            REG_OFFSET_Y: vp_off_y = value;
            REG_BF_EN:    bf_en = value[0];
            REG_FRONT_CW: front_cw = value[0];
            default: ;
        endcase
    endtask

    task automatic set_viewport(logic [31:0] sx, logic [31:0] sy, logic [31:0] ox,
                                logic [31:0] oy, logic be, logic cw);
        write_reg(REG_SCALE_X, sx);
        write_reg(REG_SCALE_Y, sy);
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_BF_EN, {31'd0, be});
        write_reg(REG_FRONT_CW, {31'd0, cw});
    endtask

    // Wait until the block has drained, plus the longest load latency.
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_tris.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // Driver: offers queued items; a transfer happens when tvalid and tready meet.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tuser  <= 1'b0;
            s_axis_tdata  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_item(pending_items.pop_front());
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() > 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= pending_items[0].cmd;
                    s_axis_tdata  <= {6'd0, pending_items[0].cw, pending_items[0].cz,
                                      pending_items[0].cy, pending_items[0].cx,
                                      pending_items[0].idx};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver backpressure, with one long hold-off counted here once requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= 0;
        end else if (recv_hold && hold_cycles < 3000) begin
            hold_cycles   <= hold_cycles + 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: compare every result transfer with the oldest expected triangle.
    always @(posedge i_clk) begin
        t_tri e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_tris.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %h", m_axis_tdata);
            end else begin
                e = expected_tris.pop_front();
                case (e.reason)
                    REASON_KEPT:    kept_seen++;
                    REASON_FRUSTUM: frustum_seen++;
                    default:        back_seen++;
                endcase
                if (m_axis_tdata[0] !== e.keep || m_axis_tdata[2:1] !== e.reason ||
                    m_axis_tdata[12:3] !== e.ia || m_axis_tdata[22:13] !== e.ib ||
                    m_axis_tdata[32:23] !== e.ic) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: triangle %0d/%0d/%0d expected keep=%0d ",
                                  "reason=%0d, got keep=%0d reason=%0d idx=%0d/%0d/%0d"},
                                 e.ia, e.ib, e.ic, e.keep, e.reason, m_axis_tdata[0],
                                 m_axis_tdata[2:1], m_axis_tdata[12:3],
                                 m_axis_tdata[22:13], m_axis_tdata[32:23]);
                end
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        vp_scale_x = 0; vp_scale_y = 0; vp_off_x = 0; vp_off_y = 0;
        bf_en = 0; front_cw = 0;
        foreach (vtx_loaded[i]) vtx_loaded[i] = 1'b0;
        send_idle_pct = 0; recv_idle_pct = 0; recv_hold = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, zero w, boundary quotients, both windings.
        set_viewport(32'sd640 << 16, 32'sd360 << 16, 32'sd640 << 16, 32'sd360 << 16,
                     1'b1, 1'b0);
        add_load(10'd0, 0, 0, 0, 32'sd65536);
        add_load(10'd1, 32'sd65536, 0, -32'sd65536, 32'sd65536);
        add_load(10'd1023, 0, 32'sd65536, 0, 32'sd65536);
        add_load(10'd2, 32'sd65537, 0, 0, 32'sd65536);
        add_load(10'd3, 1, 1, 1, 0);
        add_load(10'd4, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        add_load(10'd5, -32'sd65536, -32'sd65536, 32'sd65536, -32'sd65536);
        add_index(10'd0); add_index(10'd1); add_index(10'd1023);
        add_index(10'd0); add_index(10'd1023); add_index(10'd1);
        add_index(10'd0); add_index(10'd1); add_index(10'd2);
        add_index(10'd3); add_index(10'd1); add_index(10'd0);
        add_index(10'd4); add_index(10'd5); add_index(10'd5);
        add_index(10'd5); add_index(10'd5); add_index(10'd5);
        send_idle_pct = 11; recv_idle_pct = 81;
        wait_drained();

        // Extreme settings, clockwise front.
        set_viewport(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b1);
        add_random_phase(280);
        wait_drained();

        // Long receiver hold while the sender keeps offering.
        send_idle_pct = 81; recv_idle_pct = 11;
        set_viewport($urandom, $urandom, $urandom, $urandom, 1'b1, 1'b0);
        add_random_phase(280);
        recv_hold = 1'b1;
        wait_drained();

        // No idling; backface test off.
        send_idle_pct = 0; recv_idle_pct = 0;
        set_viewport(32'sd100 << 16, -(32'sd50 << 16), 32'sd5 << 16, 0, 1'b0, 1'b1);
        add_random_phase(280);
        wait_drained();

        $display("Checked %0d triangles over four viewport settings", results_seen);
        $display("(%0d kept, %0d frustum, %0d backface).",
                 kept_seen, frustum_seen, back_seen);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> triangle_assembly_and_cull.f
hw/rtl/tac_pkg.sv
hw/rtl/tac_div.sv
hw/rtl/tac_datapath.sv
hw/rtl/tac_ctrl.sv
hw/rtl/triangle_assembly_and_cull.sv
verif/tb.sv
